// ===== rtl/per_label_mean_stddev_top_assert.svh =====
// ----------------------------------------------------------------------------
// per_label_mean_stddev_top_assert.svh
// Assertion macros used by the per-label statistics top module.
// ----------------------------------------------------------------------------
`ifndef PER_LABEL_MEAN_STDDEV_TOP_ASSERT_SVH
`define PER_LABEL_MEAN_STDDEV_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define PLMS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define PLMS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/plms_pkg.sv =====
// ----------------------------------------------------------------------------
// plms_pkg
// Sizes, store entry layout and sequencer states for per-label statistics.
// ----------------------------------------------------------------------------
package plms_pkg;

   localparam int NUM_LABELS  = 64;
   localparam int MAX_PIXELS  = 1048576;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 8;

   // word field widths
   localparam int LABEL_W  = 6;
   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 21;
   localparam int MEAN_W   = 24;
   localparam int SD_W     = 24;

   // store geometry
   localparam int ENTRIES = NUM_LABELS - 1;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam int LOG_PIX = $clog2(MAX_PIXELS);
   localparam int CNT_W   = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W   = SAMPLE_BITS + LOG_PIX;
   localparam int SQ_W    = 2 * SAMPLE_BITS + LOG_PIX;

   // sequential multiplier: SQ_W x SUM_W in MUL_CHUNK-bit slices
   localparam int MUL_CHUNK = 16;
   localparam int MUL_STEPS = (SUM_W + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int MUL_BR_W  = MUL_STEPS * MUL_CHUNK;
   localparam int MUL_CNT_W = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;
   localparam int PROD_W    = SQ_W + SUM_W;

   // variance numerator and divider
   localparam int DIFF_W   = CNT_W + SQ_W;
   localparam int NUM_W    = DIFF_W + 2 * FRAC_BITS;
   localparam int DEN_W    = 2 * CNT_W;
   localparam int Q_W      = 2 * (SAMPLE_BITS + FRAC_BITS);
   localparam int DIV_CNT_W = $clog2(Q_W);

   // square root
   localparam int R_W      = SAMPLE_BITS + FRAC_BITS;
   localparam int SQ_CNT_W = $clog2(R_W);

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [SUM_W-1:0] sum;
      logic [SQ_W-1:0]  sumsq;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DRAIN,
      S_READ,
      S_LOAD,
      S_MUL_A,
      S_WAIT_A,
      S_MUL_B,
      S_WAIT_B,
      S_DIV_M,
      S_WAIT_M,
      S_DIV_V,
      S_WAIT_V,
      S_SQRT,
      S_WAIT_S,
      S_EMIT,
      S_FINISH
   } state_type;

endpackage

// ===== rtl/plms_if.sv =====
// ----------------------------------------------------------------------------
// plms_if
// Pixel and result channels: valid/ready with payload.
// ----------------------------------------------------------------------------
interface plms_req_if;
   logic                          valid;
   logic                          ready;
   logic [plms_pkg::LABEL_W-1:0]  label;
   logic [plms_pkg::SAMPLE_W-1:0] sample;
   logic                          last_pixel;

   modport source (output valid, label, sample, last_pixel, input ready);
   modport sink   (input valid, label, sample, last_pixel, output ready);
endinterface

interface plms_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [plms_pkg::LABEL_W-1:0] region;
   logic [plms_pkg::COUNT_W-1:0] pixel_count;
   logic [plms_pkg::MEAN_W-1:0]  mean_value;
   logic [plms_pkg::SD_W-1:0]    std_dev;
   logic                         last_region;

   modport source (output valid, region, pixel_count, mean_value, std_dev, last_region,
                   input ready);
   modport sink   (input valid, region, pixel_count, mean_value, std_dev, last_region,
                   output ready);
endinterface

// ===== rtl/per_label_mean_stddev_top.sv =====
// ----------------------------------------------------------------------------
// per_label_mean_stddev_top
// Per-label pixel count, mean and sample standard deviation over one image.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+-------------------------------------
//  req_if  | in  | valid & ready        | label, sample, last_pixel
//  rsp_if  | out | valid & ready        | region, pixel_count, mean_value,
//          |     |                      | std_dev, last_region
//
//  Accumulation takes one pixel word per cycle: store read, add, write back
//  the next cycle, with the last written entry forwarded on back-to-back hits.
//  Readout starts after the last pixel, by way of S_DRAIN, and per label runs
//  the 3-slice multiplier twice, the 48-step divider twice and the 24-step root;
//  empty and single-pixel labels skip the divisions they do not need.
//  Reset clears per-entry valid bits at once; the store itself is never swept.
//  req_if.ready is low from the last pixel until readout ends; the result
//  register holds a word while rsp_if.ready is low and the sequencer waits.
//
module per_label_mean_stddev_top (
   input  logic       clock,
   input  logic       reset,
   plms_req_if.sink   req_if,
   plms_rsp_if.source rsp_if
);

   `include "per_label_mean_stddev_top_assert.svh"

   plms_pkg::state_type state_ff, state_in;

   // ---------------- accumulation pipeline ----------------
   logic                            req_acc;
   logic                            lab_ok;
   logic [plms_pkg::LABEL_W-1:0]    lab;
   logic [plms_pkg::ADDR_W-1:0]     acc_addr, raddr;
   logic                            acc_vld_ff;
   logic [plms_pkg::ADDR_W-1:0]     acc_addr_ff;
   logic [plms_pkg::SAMPLE_BITS-1:0] acc_sample_ff;
   logic                            ent_vld_ff, use_fwd_ff;
   plms_pkg::entry_type             fwd_ff, old_ent, new_ent, rd_ent, mem_ent;
   logic [plms_pkg::ENTRY_W-1:0]    rd_data;
   logic [plms_pkg::ENTRIES-1:0]    valid_ff, valid_in;
   logic [plms_pkg::LABEL_W-1:0]    largest_ff;
   logic [2*plms_pkg::SAMPLE_BITS-1:0] sq;
   logic [plms_pkg::LABEL_W-1:0]    k_ff;

   assign lab      = req_if.label;
   assign req_acc  = req_if.valid && req_if.ready;
   assign lab_ok   = (lab != '0) && (32'(lab) < plms_pkg::NUM_LABELS);
   assign acc_addr = plms_pkg::ADDR_W'(lab - 1'b1);

   // readout borrows the read port; no pixel is in flight then
   assign raddr = (state_ff == plms_pkg::S_READ) ? plms_pkg::ADDR_W'(k_ff - 1'b1) : acc_addr;

   plms_ram #(
      .DATA_W (plms_pkg::ENTRY_W),
      .DEPTH  (plms_pkg::ENTRIES),
      .ADDR_W (plms_pkg::ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (acc_vld_ff),
      .wr_addr (acc_addr_ff),
      .wr_data (new_ent),
      .rd_addr (raddr),
      .rd_data (rd_data)
   );

   assign mem_ent = rd_data;
   assign rd_ent  = ent_vld_ff ? mem_ent : '0;           // never written: zero
   assign old_ent = use_fwd_ff ? fwd_ff : rd_ent;
   assign sq      = acc_sample_ff * acc_sample_ff;

   always_comb begin
      new_ent = old_ent;
      if (old_ent.count < plms_pkg::CNT_W'(plms_pkg::MAX_PIXELS)) begin
         new_ent.count = old_ent.count + 1'b1;
         new_ent.sum   = old_ent.sum + plms_pkg::SUM_W'(acc_sample_ff);
         new_ent.sumsq = old_ent.sumsq + plms_pkg::SQ_W'(sq);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (state_ff == plms_pkg::S_FINISH) begin
         valid_in = '0;
      end else if (acc_vld_ff) begin
         valid_in[acc_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= 1'b0;
         valid_ff   <= '0;
         largest_ff <= '0;
      end else begin
         acc_vld_ff <= req_acc && lab_ok;
         valid_ff   <= valid_in;
         if (state_ff == plms_pkg::S_FINISH) begin
            largest_ff <= '0;
         end else if (req_acc && lab_ok && (lab > largest_ff)) begin
            largest_ff <= lab;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_addr_ff   <= acc_addr;
      acc_sample_ff <= req_if.sample[plms_pkg::SAMPLE_BITS-1:0];
      ent_vld_ff    <= valid_ff[raddr];
      use_fwd_ff    <= acc_vld_ff && (acc_addr_ff == raddr);
      fwd_ff        <= new_ent;
   end

   // ---------------- readout datapath ----------------
   logic [plms_pkg::CNT_W-1:0]   n_ff;
   logic [plms_pkg::SUM_W-1:0]   s1_ff;
   logic [plms_pkg::SQ_W-1:0]    s2_ff;
   logic [plms_pkg::DEN_W-1:0]   den_ff;
   logic [plms_pkg::PROD_W-1:0]  prod_a_ff, prod_b_ff, diff;
   logic [plms_pkg::MEAN_W-1:0]  mean_ff;
   logic [plms_pkg::SD_W-1:0]    sd_ff;
   logic                         sd_ok;

   logic                         mul_start, mul_done;
   logic [plms_pkg::SQ_W-1:0]    mul_a;
   logic [plms_pkg::SUM_W-1:0]   mul_b;
   logic [plms_pkg::PROD_W-1:0]  mul_p;
   logic                         div_start, div_done;
   logic [plms_pkg::NUM_W-1:0]   div_num;
   logic [plms_pkg::DEN_W-1:0]   div_den;
   logic [plms_pkg::Q_W-1:0]     div_q;
   logic                         sqrt_start, sqrt_done;
   logic [plms_pkg::R_W-1:0]     sqrt_root;
   logic                         out_free, out_load;

   assign diff  = prod_a_ff - prod_b_ff;
   assign sd_ok = (n_ff >= plms_pkg::CNT_W'(2)) && (prod_a_ff >= prod_b_ff);

   assign mul_a = (state_ff == plms_pkg::S_MUL_A) ? s2_ff : plms_pkg::SQ_W'(s1_ff);
   assign mul_b = (state_ff == plms_pkg::S_MUL_A) ? plms_pkg::SUM_W'(n_ff) : s1_ff;

   // mean: (sum << 8) / n; variance: ((n*sq - sum^2) << 16) / (n*(n-1))
   assign div_num = (state_ff == plms_pkg::S_DIV_M)
                  ? plms_pkg::NUM_W'({s1_ff, {plms_pkg::FRAC_BITS{1'b0}}})
                  : {diff[plms_pkg::DIFF_W-1:0], {2*plms_pkg::FRAC_BITS{1'b0}}};
   assign div_den = (state_ff == plms_pkg::S_DIV_M) ? plms_pkg::DEN_W'(n_ff) : den_ff;

   plms_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   plms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   plms_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (div_q),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plms_pkg::S_IDLE:   if (req_acc && req_if.last_pixel) state_in = plms_pkg::S_DRAIN;
         plms_pkg::S_DRAIN:  state_in = (largest_ff == '0) ? plms_pkg::S_FINISH
                                                           : plms_pkg::S_READ;
         plms_pkg::S_READ:   state_in = plms_pkg::S_LOAD;
         plms_pkg::S_LOAD:   state_in = plms_pkg::S_MUL_A;
         plms_pkg::S_MUL_A:  state_in = plms_pkg::S_WAIT_A;
         plms_pkg::S_WAIT_A: if (mul_done) state_in = plms_pkg::S_MUL_B;
         plms_pkg::S_MUL_B:  state_in = plms_pkg::S_WAIT_B;
         plms_pkg::S_WAIT_B: if (mul_done) state_in = plms_pkg::S_DIV_M;
         plms_pkg::S_DIV_M:  state_in = (n_ff == '0) ? plms_pkg::S_DIV_V : plms_pkg::S_WAIT_M;
         plms_pkg::S_WAIT_M: if (div_done) state_in = plms_pkg::S_DIV_V;
         plms_pkg::S_DIV_V:  state_in = sd_ok ? plms_pkg::S_WAIT_V : plms_pkg::S_EMIT;
         plms_pkg::S_WAIT_V: if (div_done) state_in = plms_pkg::S_SQRT;
         plms_pkg::S_SQRT:   state_in = plms_pkg::S_WAIT_S;
         plms_pkg::S_WAIT_S: if (sqrt_done) state_in = plms_pkg::S_EMIT;
         plms_pkg::S_EMIT: begin
            if (out_free) begin
               state_in = (k_ff == largest_ff) ? plms_pkg::S_FINISH : plms_pkg::S_READ;
            end
         end
         plms_pkg::S_FINISH: state_in = plms_pkg::S_IDLE;
         default:            state_in = plms_pkg::S_IDLE;
      endcase
   end

   assign out_free = !rsp_if.valid || rsp_if.ready;

   always_comb begin
      req_if.ready = (state_ff == plms_pkg::S_IDLE);
      mul_start    = (state_ff == plms_pkg::S_MUL_A) || (state_ff == plms_pkg::S_MUL_B);
      div_start    = ((state_ff == plms_pkg::S_DIV_M) && (n_ff != '0))
                  || ((state_ff == plms_pkg::S_DIV_V) && sd_ok);
      sqrt_start   = (state_ff == plms_pkg::S_SQRT);
      out_load     = (state_ff == plms_pkg::S_EMIT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plms_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == plms_pkg::S_DRAIN) begin
         k_ff <= plms_pkg::LABEL_W'(1);
      end else if (out_load) begin
         k_ff <= k_ff + 1'b1;
      end
      if (state_ff == plms_pkg::S_LOAD) begin
         n_ff  <= rd_ent.count;
         s1_ff <= rd_ent.sum;
         s2_ff <= rd_ent.sumsq;
      end
      if (state_ff == plms_pkg::S_MUL_A) begin
         den_ff <= plms_pkg::DEN_W'(n_ff) * plms_pkg::DEN_W'(n_ff - 1'b1);
      end
      if ((state_ff == plms_pkg::S_WAIT_A) && mul_done) prod_a_ff <= mul_p;
      if ((state_ff == plms_pkg::S_WAIT_B) && mul_done) prod_b_ff <= mul_p;
      if ((state_ff == plms_pkg::S_DIV_M) && (n_ff == '0)) begin
         mean_ff <= '0;
      end else if ((state_ff == plms_pkg::S_WAIT_M) && div_done) begin
         mean_ff <= div_q[plms_pkg::MEAN_W-1:0];
      end
      if ((state_ff == plms_pkg::S_DIV_V) && !sd_ok) begin
         sd_ff <= '0;
      end else if ((state_ff == plms_pkg::S_WAIT_S) && sqrt_done) begin
         sd_ff <= plms_pkg::SD_W'(sqrt_root);
      end
   end

   // ---------------- result register ----------------
   logic                         rsp_valid_ff;
   logic [plms_pkg::LABEL_W-1:0] region_ff;
   logic [plms_pkg::COUNT_W-1:0] count_out_ff;
   logic [plms_pkg::MEAN_W-1:0]  mean_out_ff;
   logic [plms_pkg::SD_W-1:0]    sd_out_ff;
   logic                         last_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         region_ff    <= k_ff;
         count_out_ff <= plms_pkg::COUNT_W'(n_ff);
         mean_out_ff  <= mean_ff;
         sd_out_ff    <= sd_ff;
         last_out_ff  <= (k_ff == largest_ff);
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.region      = region_ff;
   assign rsp_if.pixel_count = count_out_ff;
   assign rsp_if.mean_value  = mean_out_ff;
   assign rsp_if.std_dev     = sd_out_ff;
   assign rsp_if.last_region = last_out_ff;

   // ---------------- checks ----------------
   `PLMS_ASSERT_NXT(ast_fwd_hit, clock, reset,
      req_acc && lab_ok && acc_vld_ff && (acc_addr_ff == acc_addr), use_fwd_ff,
      "back-to-back hit on one entry not forwarded")
   `PLMS_ASSERT_NOW(ast_read_quiet, clock, reset, state_ff == plms_pkg::S_READ,
      !acc_vld_ff, "readout read while a pixel write is pending")
   `PLMS_ASSERT_NOW(ast_region_range, clock, reset, out_load,
      (k_ff != '0) && (k_ff <= largest_ff), "result for a label beyond the maximum")
   `PLMS_ASSERT_NXT(ast_clear, clock, reset, state_ff == plms_pkg::S_FINISH,
      (valid_ff == '0) && (largest_ff == '0), "stores not cleared after readout")

endmodule

// ===== rtl/plms_ram.sv =====
// ----------------------------------------------------------------------------
// plms_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module plms_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/plms_mul.sv =====
// ----------------------------------------------------------------------------
// plms_mul
// Sequential multiplier, one MUL_CHUNK-bit slice of b per cycle.
// ----------------------------------------------------------------------------
module plms_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [plms_pkg::SQ_W-1:0]   a,
   input  logic [plms_pkg::SUM_W-1:0]  b,
   output logic                        done,
   output logic [plms_pkg::PROD_W-1:0] product
);

   logic                           busy_ff, done_ff;
   logic [plms_pkg::MUL_CNT_W-1:0] cnt_ff;
   logic [plms_pkg::SQ_W-1:0]      a_ff;
   logic [plms_pkg::MUL_BR_W-1:0]  b_ff;
   logic [plms_pkg::PROD_W-1:0]    acc_ff, acc_in;
   logic [plms_pkg::SQ_W+plms_pkg::MUL_CHUNK-1:0] part;

   assign part   = a_ff * b_ff[plms_pkg::MUL_CHUNK-1:0];
   assign acc_in = acc_ff + (plms_pkg::PROD_W'(part) << (plms_pkg::MUL_CHUNK * cnt_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == plms_pkg::MUL_CNT_W'(plms_pkg::MUL_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= plms_pkg::MUL_BR_W'(b);
         acc_ff <= '0;
      end else if (busy_ff) begin
         b_ff   <= b_ff >> plms_pkg::MUL_CHUNK;
         acc_ff <= acc_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/plms_div.sv =====
// ----------------------------------------------------------------------------
// plms_div
// Restoring divider, one quotient bit per cycle, Q_W bits.
// ----------------------------------------------------------------------------
module plms_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [plms_pkg::NUM_W-1:0] dividend,
   input  logic [plms_pkg::DEN_W-1:0] divisor,
   output logic                       done,
   output logic [plms_pkg::Q_W-1:0]   quotient
);

   logic                           busy_ff, done_ff;
   logic [plms_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [plms_pkg::DEN_W-1:0]     den_ff, rem_ff, rem_in;
   logic [plms_pkg::Q_W-1:0]       low_ff;
   logic [plms_pkg::DEN_W:0]       trial;
   logic                           ge;

   // caller guarantees the high part of the dividend is below the divisor
   assign trial  = {rem_ff, low_ff[plms_pkg::Q_W-1]};
   assign ge     = trial >= {1'b0, den_ff};
   assign rem_in = ge ? plms_pkg::DEN_W'(trial - {1'b0, den_ff})
                      : trial[plms_pkg::DEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == plms_pkg::DIV_CNT_W'(plms_pkg::Q_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= divisor;
         rem_ff <= plms_pkg::DEN_W'(dividend[plms_pkg::NUM_W-1:plms_pkg::Q_W]);
         low_ff <= dividend[plms_pkg::Q_W-1:0];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[plms_pkg::Q_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = low_ff;

endmodule

// ===== rtl/plms_sqrt.sv =====
// ----------------------------------------------------------------------------
// plms_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module plms_sqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [plms_pkg::Q_W-1:0] radicand,
   output logic                     done,
   output logic [plms_pkg::R_W-1:0] root
);

   logic                          busy_ff, done_ff;
   logic [plms_pkg::SQ_CNT_W-1:0] cnt_ff;
   logic [plms_pkg::Q_W-1:0]      rad_ff;
   logic [plms_pkg::R_W:0]        rem_ff;
   logic [plms_pkg::R_W-1:0]      root_ff;
   logic [plms_pkg::R_W+2:0]      shifted, trial;
   logic                          ge;

   assign shifted = {rem_ff, rad_ff[plms_pkg::Q_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign ge      = shifted >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == plms_pkg::SQ_CNT_W'(plms_pkg::R_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= ge ? (plms_pkg::R_W+1)'(shifted - trial) : shifted[plms_pkg::R_W:0];
         root_ff <= {root_ff[plms_pkg::R_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Per-label statistics block: streams labeled pixel words into the block,
// predicts count, mean and sample deviation for every label up to the
// largest one seen, and checks each result word in order under random idling.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [plms_pkg::LABEL_W-1:0]  label;
      logic [plms_pkg::SAMPLE_W-1:0] sample;
      logic                          last_pixel;
   } pixel_type;

   typedef struct packed {
      logic [plms_pkg::LABEL_W-1:0] region;
      logic [plms_pkg::COUNT_W-1:0] pixel_count;
      logic [plms_pkg::MEAN_W-1:0]  mean_value;
      logic [plms_pkg::SD_W-1:0]    std_dev;
      logic                         last_region;
   } region_stats_type;

   localparam int TAIL_ITEMS     = 60;     // no idling once this few remain
   localparam int STALL_LIMIT    = 20000;  // cycles with no word accepted
   localparam int DRAIN_CYCLES   = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   plms_req_if req_if ();
   plms_rsp_if rsp_if ();

   per_label_mean_stddev_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor: private copy of the per-label stores
   // ------------------------------------------------------------------------
   longint unsigned acc_sum   [1:plms_pkg::ENTRIES];
   longint unsigned acc_sumsq [1:plms_pkg::ENTRIES];
   longint unsigned acc_count [1:plms_pkg::ENTRIES];
   int unsigned     top_label;

   pixel_type        pixel_queue [$];   // words still to send
   region_stats_type stats_queue [$];   // result words still owed by the block
   bit               failed = 1'b0;

   function automatic void clear_stores();
      for (int i = 1; i <= plms_pkg::ENTRIES; i++) begin
         acc_sum[i]   = 0;
         acc_sumsq[i] = 0;
         acc_count[i] = 0;
      end
      top_label = 0;
   endfunction

   // floor(256 * sqrt((n*s2 - s1^2) / (n*(n-1)))), bit by bit, exact
   function automatic logic [plms_pkg::SD_W-1:0] sample_deviation(longint unsigned n,
                                                                  longint unsigned s1,
                                                                  longint unsigned s2);
      logic [127:0] lhs;
      logic [127:0] rhs;
      logic [127:0] num;
      logic [127:0] denom;
      logic [127:0] trial;
      logic [plms_pkg::SD_W-1:0] root;
      root = '0;
      if (n < 2) return '0;
      lhs = 128'(n) * 128'(s2);
      rhs = 128'(s1) * 128'(s1);
      if (lhs < rhs) return '0;
      num   = (lhs - rhs) << 16;
      denom = 128'(n) * 128'(n - 1);
      for (int b = plms_pkg::SD_W - 1; b >= 0; b--) begin
         trial = 128'(root | (plms_pkg::SD_W'(1) << b));
         if (num >= trial * trial * denom) root[b] = 1'b1;
      end
      return root;
   endfunction

   function automatic void accumulate_pixel(pixel_type px);
      region_stats_type rs;
      int unsigned      lab;
      lab = px.label;
      if (lab != 0 && lab < plms_pkg::NUM_LABELS) begin
         if (lab > top_label) top_label = lab;
         if (acc_count[lab] < plms_pkg::MAX_PIXELS) begin
            acc_sum[lab]   += px.sample;
            acc_sumsq[lab] += longint'(px.sample) * longint'(px.sample);
            acc_count[lab] += 1;
         end
      end
      if (!px.last_pixel) return;
      for (int k = 1; k <= top_label; k++) begin
         rs.region      = plms_pkg::LABEL_W'(k);
         rs.pixel_count = plms_pkg::COUNT_W'(acc_count[k]);
         rs.mean_value  = acc_count[k]
                        ? plms_pkg::MEAN_W'((acc_sum[k] << plms_pkg::FRAC_BITS) / acc_count[k])
                        : '0;
         rs.std_dev     = sample_deviation(acc_count[k], acc_sum[k], acc_sumsq[k]);
         rs.last_region = (k == top_label);
         stats_queue    = {stats_queue, rs};
      end
      clear_stores();
   endfunction

   // ------------------------------------------------------------------------
   // Pixel driver: loads a new word at the falling edge after acceptance
   // ------------------------------------------------------------------------
   bit req_fire;
   bit rsp_fire;
   int req_gap = 0;
   int rsp_gap = 0;

   initial begin
      req_if.valid      = 1'b0;
      req_if.label      = '0;
      req_if.sample     = '0;
      req_if.last_pixel = 1'b0;
      rsp_if.ready      = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_if.valid || req_fire) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_if.valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
               // occasionally open a burst of idle cycles before this word
               if (pixel_queue.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
                  req_gap <= $urandom_range(1, 13) - 1;
                  req_if.valid <= 1'b0;
               end else begin
                  req_if.valid      <= 1'b1;
                  req_if.label      <= pixel_queue[0].label;
                  req_if.sample     <= pixel_queue[0].sample;
                  req_if.last_pixel <= pixel_queue[0].last_pixel;
                  void'(pixel_queue.pop_front());
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end

         // result side back-pressure, also in bursts
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_if.ready <= 1'b0;
         end else if (pixel_queue.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
            rsp_gap <= $urandom_range(1, 13) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge
   // ------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      region_stats_type exp_w;
      req_fire = !reset && req_if.valid && req_if.ready;
      rsp_fire = !reset && rsp_if.valid && rsp_if.ready;

      if (req_fire)
         accumulate_pixel('{req_if.label, req_if.sample, req_if.last_pixel});

      if (rsp_fire) begin
         if (stats_queue.size() == 0) begin
            $error("unexpected result word for region %0d", rsp_if.region);
            failed = 1'b1;
         end else begin
            exp_w = stats_queue.pop_front();
            if (rsp_if.region !== exp_w.region) begin
               $error("region: expected %0d, got %0d", exp_w.region, rsp_if.region);
               failed = 1'b1;
            end
            if (rsp_if.pixel_count !== exp_w.pixel_count) begin
               $error("pixel_count: expected %0d, got %0d",
                      exp_w.pixel_count, rsp_if.pixel_count);
               failed = 1'b1;
            end
            if (rsp_if.mean_value !== exp_w.mean_value) begin
               $error("mean_value: expected %0d, got %0d",
                      exp_w.mean_value, rsp_if.mean_value);
               failed = 1'b1;
            end
            if (rsp_if.std_dev !== exp_w.std_dev) begin
               $error("std_dev: expected %0d, got %0d", exp_w.std_dev, rsp_if.std_dev);
               failed = 1'b1;
            end
            if (rsp_if.last_region !== exp_w.last_region) begin
               $error("last_region: expected %0d, got %0d",
                      exp_w.last_region, rsp_if.last_region);
               failed = 1'b1;
            end
         end
      end

      // watchdog: readout of 63 labels still yields a word well within STALL_LIMIT
      if (req_fire || rsp_fire || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic add_pixel(int unsigned lab, int unsigned smp, bit fin);
      pixel_type px;
      px.label      = plms_pkg::LABEL_W'(lab);
      px.sample     = plms_pkg::SAMPLE_W'(smp);
      px.last_pixel = fin;
      pixel_queue   = {pixel_queue, px};
   endtask

   function automatic int unsigned random_sample(int unsigned flavor, int unsigned base);
      case (flavor)
         0: return $urandom_range(0, 65535);
         1: return base + $urandom_range(0, 3);         // nearly constant region
         2: return $urandom_range(0, 1) ? 65535 : 0;    // extremes
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   initial begin
      int unsigned max_lab;
      int unsigned npix;
      int unsigned flavor;
      int unsigned base;
      int unsigned lab;
      int          total;

      clear_stores();

      // image: empty labels between, single pixel, extremes, max label
      add_pixel(1, 0, 0);
      add_pixel(1, 0, 0);
      add_pixel(0, 4660, 0);
      add_pixel(2, 12345, 0);                 // single pixel -> deviation 0
      add_pixel(5, 65535, 0);
      add_pixel(5, 0, 0);                     // widest spread
      add_pixel(5, 65535, 0);
      add_pixel(63, 65535, 0);
      add_pixel(63, 65535, 0);
      add_pixel(63, 65535, 0);
      add_pixel(42, 21845, 0);
      add_pixel(21, 43690, 0);
      add_pixel(0, 65535, 1);                 // last pixel outside any region
      // image with no labeled pixels at all: nothing comes out
      add_pixel(0, 100, 0);
      add_pixel(0, 65535, 0);
      add_pixel(0, 0, 1);
      // last pixel carries the only and largest label
      add_pixel(3, 7, 0);
      add_pixel(0, 9, 0);
      add_pixel(3, 65535, 1);
      // one-pixel image
      add_pixel(1, 32768, 1);

      total = pixel_queue.size();
      while (total < 430) begin
         if ($urandom_range(0, 11) == 0) begin
            // noise image: unlabeled pixels only
            npix = $urandom_range(1, 6);
            for (int p = 0; p < npix; p++)
               add_pixel(0, $urandom_range(0, 65535), p == npix - 1);
            total += npix;
         end else begin
            max_lab = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 63)
                                                  : $urandom_range(1, 8);
            npix    = $urandom_range(1, 30);
            flavor  = $urandom_range(0, 3);
            base    = $urandom_range(0, 65532);
            for (int p = 0; p < npix; p++) begin
               lab = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, max_lab);
               add_pixel(lab, random_sample(flavor, base), p == npix - 1);
            end
            total += npix;
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pixel_queue.size() == 0 && !req_if.valid);
      wait (stats_queue.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (!failed && stats_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
